@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL. All checks are sampled on the rising
// edge of clk and are switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every sampled edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sps_pkg.sv @@
`timescale 1ns / 1ps

package sps_pkg;

  localparam int STEP_INTERVAL_W = 24;
  localparam int PHASE_TABLE_W = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_INDEX_W = 2;

  localparam logic [STEP_INTERVAL_W-1:0] RST_STEP_INTERVAL = 24'd1000;
  localparam logic RST_FOUR_WIRE = 1'b1;
  localparam logic [PHASE_TABLE_W-1:0] RST_PHASE_TABLE = 16'h956A;

  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_INTERVAL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_WIRE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_TABLE = 2'd2;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_MOVE_TO   = 3'd1,
    ACT_MOVE_BY   = 3'd2,
    ACT_SET_POS   = 3'd3,
    ACT_COILS_OFF = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  typedef struct packed {
    logic [STEP_INTERVAL_W-1:0] step_interval;
    logic                       four_wire;
    logic [PHASE_TABLE_W-1:0]   phase_table;
  } sps_cfg_t;

  typedef struct packed {
    logic [3:0]  coils;
    logic [31:0] position;
    logic [31:0] distance_left;
    logic        running;
    logic        stepped;
  } sps_result_t;

  // Coil pattern for a phase; two-wire mode drives only the two low lines.
  function automatic logic [3:0] phase_entry(input logic [PHASE_TABLE_W-1:0] tbl,
                                             input logic four_wire,
                                             input logic [1:0] phase);
    logic [3:0] e;
    e = tbl[{phase, 2'b00} +: 4];
    if (!four_wire) begin
      e[3:2] = 2'b00;
    end
    return e;
  endfunction

  function automatic dir_t dir_of(input logic [31:0] diff);
    dir_t d;
    if (diff == 32'd0) begin
      d = DIR_NONE;
    end else if (!diff[31]) begin
      d = DIR_FWD;
    end else begin
      d = DIR_BACK;
    end
    return d;
  endfunction

endpackage

@@ rtl/core/stepper_position_sequencer_unit.sv @@
// Constant-speed stepper position sequencer.
// Requests arrive on the in_valid/in_ready channel: action selects a tick
// (one microsecond of time), an absolute move, a relative move, a position
// load or coils off, and value carries the target, distance or position.
// Every request yields exactly one result on the out_valid/out_ready channel:
// coil levels, position, distance left, running and stepped.
// The result is registered: a request accepted at one edge is in the output
// register right after that edge. Throughput is one request per cycle while
// the receiver keeps up; the whole update is a compare, an increment and a
// table lookup between the input handshake and the result register.
// When the receiver stalls, the result holds and in_ready drops until it is
// taken; in_ready is high whenever the result register is empty or drains.
// Configuration registers (interval, wire mode, phase table) are written
// through cfg_write/cfg_index/cfg_data, by the user only while no request is in flight (unenforced by the block).
// Reset clears position, target, direction, tick counter and coils, and
// loads the configuration defaults: 1000 ticks, four wires, table 0x956A.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stepper_position_sequencer_unit
  import sps_pkg::*;
#(
  parameter int INTERVAL_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             action,
  input  logic signed [31:0]     value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             coils,
  output logic signed [31:0]     position,
  output logic signed [31:0]     distance_left,
  output logic                   running,
  output logic                   stepped
);

  sps_cfg_t    cfg;
  sps_result_t result_next;
  sps_result_t result;
  logic        fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_interval <= RST_STEP_INTERVAL;
      cfg.four_wire <= RST_FOUR_WIRE;
      cfg.phase_table <= RST_PHASE_TABLE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STEP_INTERVAL: cfg.step_interval <= cfg_data[STEP_INTERVAL_W-1:0];
        CFG_FOUR_WIRE:     cfg.four_wire <= cfg_data[0];
        CFG_PHASE_TABLE:   cfg.phase_table <= cfg_data[PHASE_TABLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign fire = in_valid && in_ready;

  sps_motion #(
    .INTERVAL_BITS(INTERVAL_BITS)
  ) u_motion (
    .clk    (clk),
    .rst    (rst),
    .accept (fire),
    .action (action),
    .value  (value),
    .cfg    (cfg),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  assign coils = result.coils;
  assign position = result.position;
  assign distance_left = result.distance_left;
  assign running = result.running;
  assign stepped = result.stepped;

  `ASSERT_IMPLY(a_running_matches, out_valid, running == (distance_left != 32'sd0), "running disagrees with distance")
  `ASSERT_NEXT(a_cmd_no_step, fire && (action != ACT_TICK), !stepped, "command reported a step")
  `ASSERT_IMPLY(a_two_wire_lines, out_valid && stepped && !cfg.four_wire, coils[3:2] == 2'b00, "upper coil lines driven in two-wire mode")

endmodule

@@ rtl/core/sps_motion.sv @@
`timescale 1ns / 1ps

module sps_motion
  import sps_pkg::*;
#(
  parameter int INTERVAL_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [2:0]  action,
  input  logic [31:0] value,
  input  sps_cfg_t    cfg,
  output sps_result_t result
);

  localparam int CW = (INTERVAL_BITS > STEP_INTERVAL_W) ? INTERVAL_BITS : STEP_INTERVAL_W;
  localparam logic [CW-1:0] LIMIT_MAX = CW'((64'd1 << INTERVAL_BITS) - 64'd1);
  localparam logic [INTERVAL_BITS-1:0] TICKS_MAX = '1;

  logic [31:0]              cur;
  logic [31:0]              tgt;
  logic [31:0]              remain;
  dir_t                     dir;
  logic [INTERVAL_BITS-1:0] ticks;
  logic [3:0]               coil;

  logic [31:0]              cur_next;
  logic [31:0]              tgt_next;
  logic [31:0]              remain_next;
  dir_t                     dir_next;
  logic [INTERVAL_BITS-1:0] ticks_next;
  logic [3:0]               coil_next;
  logic                     stepped;

  logic [CW-1:0]            limit;
  logic [INTERVAL_BITS-1:0] elapsed;
  logic                     due;
  logic [31:0]              delta;
  logic [31:0]              cur_stepped;

  always_comb begin
    limit = (CW'(cfg.step_interval) > LIMIT_MAX) ? LIMIT_MAX : CW'(cfg.step_interval);
    elapsed = (ticks == TICKS_MAX) ? ticks : ticks + INTERVAL_BITS'(1);
    due = (remain != 32'd0) && (CW'(elapsed) >= limit);
    // A due tick with no latched direction still rewrites the coils.
    case (dir)
      DIR_FWD:  delta = 32'd1;
      DIR_BACK: delta = 32'hFFFF_FFFF;
      default:  delta = 32'd0;
    endcase
    cur_stepped = cur + delta;
  end

  always_comb begin
    cur_next = cur;
    tgt_next = tgt;
    remain_next = remain;
    dir_next = dir;
    ticks_next = ticks;
    coil_next = coil;
    stepped = 1'b0;
    unique case (action)
      ACT_TICK: begin
        if (due) begin
          cur_next = cur_stepped;
          remain_next = remain - delta;
          coil_next = phase_entry(cfg.phase_table, cfg.four_wire, cur_stepped[1:0]);
          ticks_next = '0;
          stepped = 1'b1;
        end else begin
          ticks_next = elapsed;
        end
      end
      ACT_MOVE_TO: begin
        tgt_next = value;
        remain_next = value - cur;
        dir_next = dir_of(value - cur);
      end
      ACT_MOVE_BY: begin
        tgt_next = cur + value;
        remain_next = value;
        dir_next = dir_of(value);
      end
      ACT_SET_POS: begin
        cur_next = value;
        remain_next = tgt - value;
      end
      ACT_COILS_OFF: begin
        coil_next = 4'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      tgt <= '0;
      remain <= '0;
      dir <= DIR_NONE;
      ticks <= '0;
      coil <= '0;
    end else if (accept) begin
      cur <= cur_next;
      tgt <= tgt_next;
      remain <= remain_next;
      dir <= dir_next;
      ticks <= ticks_next;
      coil <= coil_next;
    end
  end

  always_comb begin
    result.coils = coil_next;
    result.position = cur_next;
    result.distance_left = remain_next;
    result.running = (remain_next != 32'd0);
    result.stepped = stepped;
  end

endmodule
